@@ rtl/bscs_pkg.sv @@
// Shared constants, types and helper functions of the bitmap set/clear/scan block.
package bscs_pkg;

   localparam int TOTAL_BITS = 1024;
   localparam int WORD_BITS  = 64;
   localparam int NWORDS     = (TOTAL_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int WADDR_W    = $clog2(NWORDS);
   localparam int BIT_W      = $clog2(WORD_BITS);
   localparam int KIND_W     = 3;
   localparam int POS_W      = 10;
   localparam int WNUM_W     = 4;
   localparam int LEN_W      = 11;
   localparam int CNT_W      = 11;
   localparam int CNT_MAX    = 2047;
   localparam int LEN_RESET  = 1024;
   localparam int BYTE_W     = 8;
   localparam int NBYTES     = WORD_BITS / BYTE_W;
   localparam int BSEL_W     = $clog2(NBYTES);
   localparam int BCNT_W     = $clog2(BYTE_W + 1);
   localparam int SUM_W      = BIT_W + 1;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 2;

   typedef enum logic [KIND_W-1:0] {
      KIND_SET        = 3'd0,
      KIND_CLEAR      = 3'd1,
      KIND_TEST       = 3'd2,
      KIND_COUNT      = 3'd3,
      KIND_LIST_ONES  = 3'd4,
      KIND_LIST_ZEROS = 3'd5
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACCESS,
      ST_COUNT,
      ST_COUNT_END,
      ST_SCAN_LOAD,
      ST_SCAN
   } state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load_item;
      logic read_item;
      logic read_count;
      logic count_start;
      logic load_scan;
      logic emit_single;
      logic emit_list;
      logic write;
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic out_free;
      logic item_error;
      logic scan_empty;
      logic scan_last;
      logic count_at_end;
      logic count_busy;
   } status_type;

   // Clamp the configured length to the storage size
   function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] lb);
      logic [LEN_W-1:0] len;
      len = (lb > LEN_W'(TOTAL_BITS)) ? LEN_W'(TOTAL_BITS) : lb;
      return len;
   endfunction

   // Bits of word w that lie below the logical length
   function automatic logic [WORD_BITS-1:0] word_mask(input logic [LEN_W-1:0] len,
                                                      input logic [WADDR_W-1:0] w);
      logic [LEN_W:0]         base;
      logic [WORD_BITS-1:0]   m;
      base = (LEN_W + 1)'(w) << BIT_W;
      for (int i = 0; i < WORD_BITS; i++) begin
         m[i] = (base + (LEN_W + 1)'(i)) < {1'b0, len};
      end
      return m;
   endfunction

   // Number of ones in one byte
   function automatic logic [BCNT_W-1:0] byte_ones(input logic [BYTE_W-1:0] b);
      logic [BCNT_W-1:0] c;
      c = '0;
      for (int i = 0; i < BYTE_W; i++) begin
         c = c + BCNT_W'(b[i]);
      end
      return c;
   endfunction

   // Index of the lowest set bit: pick the lowest nonzero byte, then the bit in it
   function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
      logic [NBYTES-1:0]         nz;
      logic [BSEL_W-1:0]         bsel;
      logic [BYTE_W-1:0]         byt;
      logic [BIT_W-BSEL_W-1:0]   bsub;
      for (int i = 0; i < NBYTES; i++) begin
         nz[i] = |v[i*BYTE_W +: BYTE_W];
      end
      bsel = '0;
      for (int i = NBYTES - 1; i >= 0; i--) begin
         if (nz[i]) bsel = BSEL_W'(i);
      end
      byt = v[bsel*BYTE_W +: BYTE_W];
      bsub = '0;
      for (int i = BYTE_W - 1; i >= 0; i--) begin
         if (byt[i]) bsub = (BIT_W - BSEL_W)'(i);
      end
      return {bsel, bsub};
   endfunction

endpackage

@@ rtl/bscs_if.sv @@
// Request and response channel interfaces of the bitmap set/clear/scan block.
interface bscs_req_if import bscs_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [KIND_W-1:0]  kind;
   logic [POS_W-1:0]   bit_position;
   logic [WNUM_W-1:0]  word_number;

   modport source (output valid, output kind, output bit_position, output word_number,
                   input ready);
   modport sink   (input valid, input kind, input bit_position, input word_number,
                   output ready);
endinterface

interface bscs_rsp_if import bscs_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [POS_W-1:0]   found_index;
   logic               bit_value;
   logic [CNT_W-1:0]   ones_total;
   logic               empty_res;
   logic               error;
   logic               last;

   modport source (output valid, output found_index, output bit_value, output ones_total,
                   output empty_res, output error, output last, input ready);
   modport sink   (input valid, input found_index, input bit_value, input ones_total,
                   input empty_res, input error, input last, output ready);
endinterface

@@ rtl/bitmap_set_clear_scan_core.sv @@
// Top level of the bitmap set/clear/scan block: register port, controller and datapath.
//
// A 1024-bit bitmap held as sixteen 64-bit words, all zero after reset.
// Requests arrive on req_ch (valid/ready); each carries a kind, a bit position
// and a word number. Results leave on rsp_ch through one output register, and
// last marks the final result of each request.
// Set, clear and test: one word read from the word memory, written back modified
// for set and clear; the result is loaded into the output register when it is free,
// and a request is taken only after its result has been loaded.
// Count: the sixteen words are read one per cycle into a two-stage popcount
// pipeline; the total is loaded once it is drained and the output register is free.
// List ones / list zeros: the word is read, then masked into the scan residue, then
// one result per cycle comes from the lowest-set-bit search, unless rsp_ch stalls.
// A new request is taken only between requests; a stalled rsp_ch holds the
// result register and stalls the sequence, without losing any result.
// Reset (synchronous) clears the per-word valid bits, so the bitmap reads as
// zero at once with no clearing pass; logical_bits returns to 1024.
// The logical_bits register sits at APB address 0 (aliased at all addresses); the user
// writes it only while no request is in progress, which the block does not enforce.
module bitmap_set_clear_scan_core import bscs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   bscs_req_if.sink              req_ch,
   bscs_rsp_if.source            rsp_ch,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [LEN_W-1:0] logical_bits_ff;
   cmd_type          cmd;
   status_type       status;
   logic             csr_write;

   // Configuration register
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         logical_bits_ff <= LEN_W'(LEN_RESET);
      end else if (csr_write) begin
         logical_bits_ff <= csr_pwdata[LEN_W-1:0];
      end
   end

   // Single register: every address reads it back
   assign csr_prdata = (csr_paddr == '0 || csr_paddr != '0) ?
                       CSR_DATA_W'(logical_bits_ff) : '0;

   bscs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_kind  (req_ch.kind),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   bscs_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_kind         (req_ch.kind),
      .req_bit_position (req_ch.bit_position),
      .req_word_number  (req_ch.word_number),
      .logical_bits     (logical_bits_ff),
      .rsp_ch           (rsp_ch)
   );

`ifndef NO_ASSERTIONS
   // A result is loaded only when the output register can take it
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_single || cmd.emit_list) |-> status.out_free)
      else $error("result loaded into a full output register");

   // Single and list results are never loaded together
   a_emit_one: assert property (@(posedge clock) disable iff (reset)
      !(cmd.emit_single && cmd.emit_list))
      else $error("two result sources at once");

   // After a request is taken the block is busy with it
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("request taken while another is in progress");

   // Error and empty results always end their request
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && (rsp_ch.error || rsp_ch.empty_res)) |-> rsp_ch.last)
      else $error("error or empty result without last");
`endif

endmodule

@@ rtl/bscs_ctrl.sv @@
// Sequencing state machine of the bitmap set/clear/scan block.
module bscs_ctrl import bscs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [KIND_W-1:0] req_kind,
   output logic              req_ready,
   input  status_type        status,
   output cmd_type           cmd
);

   state_type state_ff;
   state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_kind) inside
                  KIND_COUNT:                      state_in = ST_COUNT;
                  KIND_LIST_ONES, KIND_LIST_ZEROS: state_in = ST_SCAN_LOAD;
                  default:                         state_in = ST_ACCESS;
               endcase
            end
         end
         ST_ACCESS: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         ST_COUNT: begin
            if (status.count_at_end) state_in = ST_COUNT_END;
         end
         ST_COUNT_END: begin
            if (!status.count_busy && status.out_free) state_in = ST_IDLE;
         end
         ST_SCAN_LOAD: begin
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (status.out_free &&
                (status.item_error || status.scan_empty || status.scan_last)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Commands
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_item   = 1'b1;
               cmd.read_item   = 1'b1;
               cmd.count_start = (req_kind == KIND_COUNT);
            end
         end
         ST_ACCESS: begin
            if (status.out_free) begin
               cmd.emit_single = 1'b1;
               cmd.write       = 1'b1;
            end
         end
         ST_COUNT: begin
            cmd.read_count = 1'b1;
         end
         ST_COUNT_END: begin
            cmd.emit_single = !status.count_busy && status.out_free;
         end
         ST_SCAN_LOAD: begin
            cmd.load_scan = 1'b1;
         end
         ST_SCAN: begin
            if (status.out_free) begin
               if (status.item_error || status.scan_empty) begin
                  cmd.emit_single = 1'b1;
               end else begin
                  cmd.emit_list = 1'b1;
               end
            end
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

@@ rtl/bscs_datapath.sv @@
// Word storage, count pipeline, scan residue and result register of the bitmap block.
module bscs_datapath import bscs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output status_type        status,
   input  logic [KIND_W-1:0] req_kind,
   input  logic [POS_W-1:0]  req_bit_position,
   input  logic [WNUM_W-1:0] req_word_number,
   input  logic [LEN_W-1:0]  logical_bits,
   bscs_rsp_if.source        rsp_ch
);

   // Item registers
   logic [KIND_W-1:0]    kind_ff;
   logic [POS_W-1:0]     pos_ff;
   logic [WNUM_W-1:0]    wn_ff;

   // Word memory with per-word valid bits
   logic [WORD_BITS-1:0] mem_ff [NWORDS];
   logic [NWORDS-1:0]    word_valid_ff;
   logic [WORD_BITS-1:0] rd_data_ff;
   logic                 rd_valid_ff;
   logic [WADDR_W-1:0]   rd_idx_ff;
   logic [WADDR_W-1:0]   rd_addr;
   logic                 rd_en;
   logic [WORD_BITS-1:0] word;

   // Count pipeline
   logic [WADDR_W-1:0]   cnt_addr_ff;
   logic                 pend0_ff;
   logic                 pend1_ff;
   logic [BCNT_W-1:0]    bc_ff [NBYTES];
   logic [CNT_W-1:0]     acc_ff;
   logic [SUM_W-1:0]     bsum;
   logic [CNT_W:0]       acc_sum;
   logic [WORD_BITS-1:0] cnt_word;

   // Scan
   logic [WORD_BITS-1:0] residue_ff;
   logic [WORD_BITS-1:0] residue_in;
   logic [BIT_W-1:0]     low_idx;

   // Result register
   logic                 rsp_valid_ff;
   logic [POS_W-1:0]     found_ff;
   logic                 bitv_ff;
   logic [CNT_W-1:0]     total_ff;
   logic                 empty_ff;
   logic                 err_ff;
   logic                 last_ff;

   logic [LEN_W-1:0]     len;
   logic                 pos_err;
   logic                 wn_err;
   logic                 item_error;
   logic [WADDR_W-1:0]   pos_word;
   logic [WORD_BITS-1:0] pos_onehot;
   logic                 wr_en;
   logic [WORD_BITS-1:0] wr_data;

   // Single-result fields
   logic                 s_bitv;
   logic [CNT_W-1:0]     s_total;
   logic                 s_empty;
   logic                 s_err;

   assign len        = eff_len(logical_bits);
   assign pos_word   = pos_ff[POS_W-1:BIT_W];
   assign pos_onehot = WORD_BITS'(1) << pos_ff[BIT_W-1:0];
   assign pos_err    = (LEN_W'(pos_ff) >= len);
   assign wn_err     = ((LEN_W'(wn_ff) << BIT_W) >= len);
   assign word       = rd_valid_ff ? rd_data_ff : '0;

   // Capture the item
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         kind_ff <= req_kind;
         pos_ff  <= req_bit_position;
         wn_ff   <= req_word_number;
      end
   end

   // Select the read address
   always_comb begin
      rd_en = cmd.read_item || cmd.read_count;
      if (cmd.read_item) begin
         if (req_kind == KIND_LIST_ONES || req_kind == KIND_LIST_ZEROS) begin
            rd_addr = WADDR_W'(req_word_number);
         end else begin
            rd_addr = req_bit_position[POS_W-1:BIT_W];
         end
      end else begin
         rd_addr = cnt_addr_ff;
      end
   end

   // Read-modify-write of one bit
   assign wr_en   = cmd.write && !pos_err &&
                    (kind_ff == KIND_SET || kind_ff == KIND_CLEAR);
   assign wr_data = (kind_ff == KIND_SET) ? (word | pos_onehot) : (word & ~pos_onehot);

   // Memory array
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[pos_word] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
         rd_idx_ff  <= rd_addr;
      end
   end

   // Valid bits stand for the all-zero reset of the words
   always_ff @(posedge clock) begin
      if (reset) begin
         word_valid_ff <= '0;
         rd_valid_ff   <= 1'b0;
      end else begin
         if (wr_en) word_valid_ff[pos_word] <= 1'b1;
         if (rd_en) rd_valid_ff <= word_valid_ff[rd_addr];
      end
   end

   // Advance the count address and pipeline flags
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_addr_ff <= '0;
         pend0_ff    <= 1'b0;
         pend1_ff    <= 1'b0;
      end else begin
         if (cmd.count_start) begin
            cnt_addr_ff <= '0;
         end else if (cmd.read_count) begin
            cnt_addr_ff <= cnt_addr_ff + WADDR_W'(1);
         end
         pend0_ff <= cmd.read_count;
         pend1_ff <= pend0_ff;
      end
   end

   // Per-byte popcount of the masked word
   assign cnt_word = word & word_mask(len, rd_idx_ff);

   always_ff @(posedge clock) begin
      if (pend0_ff) begin
         for (int i = 0; i < NBYTES; i++) begin
            bc_ff[i] <= byte_ones(cnt_word[i*BYTE_W +: BYTE_W]);
         end
      end
   end

   // Sum the byte counts into the saturating total
   always_comb begin
      bsum = '0;
      for (int i = 0; i < NBYTES; i++) begin
         bsum = bsum + SUM_W'(bc_ff[i]);
      end
      acc_sum = {1'b0, acc_ff} + (CNT_W + 1)'(bsum);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (cmd.count_start) begin
         acc_ff <= '0;
      end else if (pend1_ff) begin
         acc_ff <= (acc_sum > (CNT_W + 1)'(CNT_MAX)) ? CNT_W'(CNT_MAX) : acc_sum[CNT_W-1:0];
      end
   end

   // Scan residue: load masked word, drop the lowest bit per listed index
   assign low_idx    = lowest_set(residue_ff);
   assign residue_in = residue_ff & ~(WORD_BITS'(1) << low_idx);

   always_ff @(posedge clock) begin
      if (reset) begin
         residue_ff <= '0;
      end else if (cmd.load_scan) begin
         residue_ff <= ((kind_ff == KIND_LIST_ONES) ? word : ~word) &
                       word_mask(len, WADDR_W'(wn_ff));
      end else if (cmd.emit_list) begin
         residue_ff <= residue_in;
      end
   end

   // Form the single-result fields
   always_comb begin
      s_bitv     = 1'b0;
      s_total    = '0;
      s_empty    = 1'b0;
      s_err      = 1'b0;
      item_error = 1'b0;
      case (kind_ff) inside
         KIND_SET, KIND_CLEAR: begin
            s_err      = pos_err;
            item_error = pos_err;
         end
         KIND_TEST: begin
            s_err      = pos_err;
            item_error = pos_err;
            s_bitv     = !pos_err && word[pos_ff[BIT_W-1:0]];
         end
         KIND_COUNT: begin
            s_total = acc_ff;
         end
         KIND_LIST_ONES, KIND_LIST_ZEROS: begin
            s_err      = wn_err;
            item_error = wn_err;
            s_empty    = !wn_err;
         end
         default: begin
            s_err      = 1'b1;
            item_error = 1'b1;
         end
      endcase
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_single || cmd.emit_list) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_single) begin
         found_ff <= '0;
         bitv_ff  <= s_bitv;
         total_ff <= s_total;
         empty_ff <= s_empty;
         err_ff   <= s_err;
         last_ff  <= 1'b1;
      end else if (cmd.emit_list) begin
         found_ff <= {wn_ff, low_idx};
         bitv_ff  <= 1'b0;
         total_ff <= '0;
         empty_ff <= 1'b0;
         err_ff   <= 1'b0;
         last_ff  <= (residue_in == '0);
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.found_index = found_ff;
   assign rsp_ch.bit_value   = bitv_ff;
   assign rsp_ch.ones_total  = total_ff;
   assign rsp_ch.empty_res   = empty_ff;
   assign rsp_ch.error       = err_ff;
   assign rsp_ch.last        = last_ff;

   // Status back to the controller
   assign status.out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign status.item_error   = item_error;
   assign status.scan_empty   = (residue_ff == '0);
   assign status.scan_last    = (residue_in == '0);
   assign status.count_at_end = (cnt_addr_ff == WADDR_W'(NWORDS - 1));
   assign status.count_busy   = pend0_ff || pend1_ff;

endmodule
